[hw/rtl/stick_tilt_centering_scaler_macros.svh]
// ----------------------------------------------------------------------------
// Stick/tilt centering scaler - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STICK_TILT_CENTERING_SCALER_MACROS_SVH
`define STICK_TILT_CENTERING_SCALER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define STCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define STCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stcs_pkg.sv]
// ----------------------------------------------------------------------------
// Stick/tilt centering scaler - package
// Result field widths, result item layout and scaling constants.
// ----------------------------------------------------------------------------
package stcs_pkg;

    localparam int OFFSET_W    = 11;
    localparam int PCT_W       = 8;
    // Percentage magnitude never exceeds 100, so seven bits are enough
    localparam int QUO_W       = 7;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * OFFSET_W - 2 * PCT_W;

    localparam int OFFSET_MAX  = 1023;
    localparam int OFFSET_MIN  = -1024;

    typedef logic signed [OFFSET_W-1:0] t_offset;
    typedef logic signed [PCT_W-1:0]    t_pct;

    // Result item, offset_x in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        t_pct                 percent_y;
        t_pct                 percent_x;
        t_offset              offset_y;
        t_offset              offset_x;
    } t_out_item;

endpackage

[hw/rtl/stick_tilt_centering_scaler.sv]
// ----------------------------------------------------------------------------
// Stick/tilt centering scaler
// Tracks source mode and home position per controller sample and reports
// offsets from home plus each offset as a percentage of the available travel.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                     | tuser
//  s_axis   | in        | stick_x, stick_y, tilt_x, tilt_y,      | -
//           |           | mode_button, home_button, zero pad     |
//  m_axis   | out       | offset_x, offset_y, percent_x,         | source_mode
//           |           | percent_y, zero pad                    |
//
//  Each item passes through these steps in order: accept, then for each
//  axis a load state and seven restoring-divider steps (one quotient bit
//  a cycle), then a done state that hands the result to the output register.
//  A full output register stalls the block in its done state until taken;
//  a new item is accepted while the previous result still waits.
//  Reset (synchronous, active low) clears mode, button history and the
//  homed flag; the first accepted item is always captured as home.
// ----------------------------------------------------------------------------
module stick_tilt_centering_scaler #(
    parameter int STICK_BITS = 8,
    parameter int TILT_BITS  = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // stick_x, stick_y, tilt_x, tilt_y, mode_button, home_button, zero pad
    input  logic [((2*STICK_BITS+2*TILT_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // offset_x, offset_y, percent_x, percent_y, zero pad
    output logic [stcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // source_mode
    output logic m_axis_tuser
);

    import stcs_pkg::*;

    localparam int DW     = (STICK_BITS > TILT_BITS) ? STICK_BITS : TILT_BITS;
    localparam int OW     = DW + 1;
    localparam int NW     = DW + QUO_W;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam int SY_LSB = STICK_BITS;
    localparam int TX_LSB = 2 * STICK_BITS;
    localparam int TY_LSB = 2 * STICK_BITS + TILT_BITS;
    localparam int MB_POS = 2 * STICK_BITS + 2 * TILT_BITS;
    localparam int HB_POS = MB_POS + 1;

    localparam logic [DW-1:0]    STICK_MAX = DW'({STICK_BITS{1'b1}});
    localparam logic [DW-1:0]    TILT_MAX  = DW'({TILT_BITS{1'b1}});
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Control state
    logic [1:0]       r_state, n_state;
    logic             r_axis;
    logic [CNT_W-1:0] r_cnt;
    logic             r_mode;
    logic             r_prev_mb;
    logic             r_prev_hb;
    logic             r_homed;
    logic             r_out_valid;

    // Payload
    logic [STICK_BITS-1:0] r_home_sx, r_home_sy;
    logic [TILT_BITS-1:0]  r_home_tx, r_home_ty;
    logic signed [OW-1:0]  r_off_x, r_off_y;
    logic [DW-1:0]         r_den_x, r_den_y;
    logic [NW-1:0]         r_rem, r_dsh;
    logic [QUO_W-1:0]      r_quo;
    logic                  r_neg, r_zero;
    t_pct                  r_pct_x, r_pct_y;
    t_out_item             r_out_data;
    logic                  r_out_user;

    // Input field unpacking
    logic [STICK_BITS-1:0] in_sx, in_sy;
    logic [TILT_BITS-1:0]  in_tx, in_ty;
    logic                  in_mb, in_hb, in_acc;

    // Sample-time update
    logic                  mode_new, capture;
    logic [STICK_BITS-1:0] home_sx_new, home_sy_new;
    logic [TILT_BITS-1:0]  home_tx_new, home_ty_new;
    logic [DW-1:0]         act_x, act_y, home_x, home_y, max_v;
    logic signed [OW-1:0]  off_x, off_y;
    logic [DW-1:0]         den_x, den_y;

    // Divider
    logic signed [OW-1:0]  sel_off;
    logic [OW-1:0]         off_u, mag_full;
    logic [DW-1:0]         sel_den, mag;
    logic [NW-1:0]         rem_init, dsh_init;
    logic                  ge;
    logic [QUO_W-1:0]      q_next;
    logic [PCT_W-1:0]      pct_mag, pct_val;
    logic                  out_load;

    function automatic t_offset sat_offset(input logic signed [31:0] v);
        t_offset res;
        if (v > OFFSET_MAX) begin
            res = t_offset'(OFFSET_MAX);
        end else if (v < OFFSET_MIN) begin
            res = t_offset'(OFFSET_MIN);
        end else begin
            res = v[OFFSET_W-1:0];
        end
        return res;
    endfunction

    // Unpack the input item
    assign in_sx  = s_axis_tdata[SY_LSB-1:0];
    assign in_sy  = s_axis_tdata[SY_LSB +: STICK_BITS];
    assign in_tx  = s_axis_tdata[TX_LSB +: TILT_BITS];
    assign in_ty  = s_axis_tdata[TY_LSB +: TILT_BITS];
    assign in_mb  = s_axis_tdata[MB_POS];
    assign in_hb  = s_axis_tdata[HB_POS];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    // Toggle mode on a mode button press, capture home on a home press or first item
    assign mode_new    = r_mode ^ (in_mb & ~r_prev_mb);
    assign capture     = (in_hb & ~r_prev_hb) | ~r_homed;
    assign home_sx_new = capture ? in_sx : r_home_sx;
    assign home_sy_new = capture ? in_sy : r_home_sy;
    assign home_tx_new = capture ? in_tx : r_home_tx;
    assign home_ty_new = capture ? in_ty : r_home_ty;

    // Select the active source and form offsets and divisors
    assign act_x  = mode_new ? DW'(in_tx) : DW'(in_sx);
    assign act_y  = mode_new ? DW'(in_ty) : DW'(in_sy);
    assign home_x = mode_new ? DW'(home_tx_new) : DW'(home_sx_new);
    assign home_y = mode_new ? DW'(home_ty_new) : DW'(home_sy_new);
    assign max_v  = mode_new ? TILT_MAX : STICK_MAX;

    assign off_x = $signed({1'b0, act_x}) - $signed({1'b0, home_x});
    assign off_y = $signed({1'b0, act_y}) - $signed({1'b0, home_y});
    assign den_x = (!off_x[OW-1] && (off_x != '0)) ? (max_v - home_x) : home_x;
    assign den_y = (!off_y[OW-1] && (off_y != '0)) ? (max_v - home_y) : home_y;

    // Divider load: numerator is |offset| * 100, divisor aligned to the top quotient bit
    assign sel_off  = r_axis ? r_off_y : r_off_x;
    assign sel_den  = r_axis ? r_den_y : r_den_x;
    assign off_u    = sel_off;
    assign mag_full = off_u[OW-1] ? (~off_u + 1'b1) : off_u;
    assign mag      = mag_full[DW-1:0];
    assign rem_init = (NW'(mag) << 6) + (NW'(mag) << 5) + (NW'(mag) << 2);
    assign dsh_init = NW'(sel_den) << (QUO_W - 1);

    // One restoring step per cycle
    assign ge      = (r_rem >= r_dsh);
    assign q_next  = {r_quo[QUO_W-2:0], ge};
    assign pct_mag = PCT_W'(q_next);
    assign pct_val = r_zero ? '0 : (r_neg ? (~pct_mag + 1'b1) : pct_mag);

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Sequence the two axes through the shared divider
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = r_axis ? ST_DONE : ST_LOAD;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_mode      <= 1'b0;
            r_prev_mb   <= 1'b0;
            r_prev_hb   <= 1'b0;
            r_homed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_mode    <= mode_new;
                r_prev_mb <= in_mb;
                r_prev_hb <= in_hb;
                r_homed   <= 1'b1;
                r_axis    <= 1'b0;
            end
            if (r_state == ST_LOAD) begin
                r_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_axis <= 1'b1;
                end
            end
            // Hold the result until the output side takes it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_home_sx <= home_sx_new;
            r_home_sy <= home_sy_new;
            r_home_tx <= home_tx_new;
            r_home_ty <= home_ty_new;
            r_off_x   <= off_x;
            r_off_y   <= off_y;
            r_den_x   <= den_x;
            r_den_y   <= den_y;
        end
        if (r_state == ST_LOAD) begin
            r_rem  <= rem_init;
            r_dsh  <= dsh_init;
            r_quo  <= '0;
            r_neg  <= sel_off[OW-1];
            r_zero <= (sel_off == '0);
        end else if (r_state == ST_DIV) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= q_next;
            if (r_cnt == LAST_STEP) begin
                if (r_axis) begin
                    r_pct_y <= pct_val;
                end else begin
                    r_pct_x <= pct_val;
                end
            end
        end
        if (out_load) begin
            r_out_data.pad       <= '0;
            r_out_data.percent_y <= r_pct_y;
            r_out_data.percent_x <= r_pct_x;
            r_out_data.offset_y  <= sat_offset(32'(r_off_y));
            r_out_data.offset_x  <= sat_offset(32'(r_off_x));
            r_out_user           <= r_mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Checks
    `include "stick_tilt_centering_scaler_macros.svh"

    `STCS_ASSERT_NEXT(a_accept_starts_x, s_axis_tvalid && s_axis_tready, (r_state == ST_LOAD) && !r_axis && r_homed, "accepted item did not start the X axis with home captured")
    `STCS_ASSERT_SAME(a_pct_range, m_axis_tvalid, (r_out_data.percent_x >= -8'sd100) && (r_out_data.percent_x <= 8'sd100) && (r_out_data.percent_y >= -8'sd100) && (r_out_data.percent_y <= 8'sd100), "percentage outside -100..100")
    `STCS_ASSERT_NEXT(a_done_hands_over, (r_state == ST_DONE) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && (r_state == ST_IDLE), "finished result not handed to the output register")

endmodule
